FILE: hdl/hhr_pkg.sv
package hhr_pkg;

    // Percentages after clamping: 0 to 1600 sixteenths of a percent.
    localparam int PCT_W = 11;
    localparam logic [PCT_W-1:0] PCT_FULL = 11'd1600;

    // Raw widths of the request fields.
    localparam int HUE_W = 16;
    localparam int PCT_IN_W = 12;

    // Channel count and the hue slope term, in units of 1/480, range -480..480.
    localparam int NUM_CH = 3;
    localparam int M_W = 10;

    // Channel numerator (signed) and denominator (positive) of x = num / den.
    localparam int NUM_W = 34;
    localparam int DEN_W = 31;

    // Rounding divider: N = num*510 + den, D = 2*den, quotient in 0..255.
    localparam int DIVN_W = 40;
    localparam int DIVD_W = 32;
    localparam int Q_W = 8;

    // Fixed denominators and scale factors.
    localparam logic [DEN_W-1:0] HSL_DEN = 31'd1228800000;  // 1600*1600*480
    localparam logic [DEN_W-1:0] HWB_DEN = 31'd1536000;     // 2*480*1600
    localparam logic [NUM_W-1:0] HSL_LSCALE = 34'd768000;   // 1600*480
    localparam logic [NUM_W-1:0] HWB_WSCALE = 34'd960;      // 2*480
    localparam logic [NUM_W-1:0] K_UNIT = 34'd480;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CLS_HSL,
        CLS_HWB,
        CLS_GREY
    } cls_t;

    // One classified color as handed from the front part to the back part.
    typedef struct packed {
        cls_t                         cls;
        logic [PCT_W-1:0]             p1;
        logic [PCT_W-1:0]             p2;
        logic [PCT_W-1:0]             mn;
        logic [PCT_W-1:0]             rest;
        logic [NUM_CH-1:0][M_W-1:0]   m;
    } item_t;

endpackage

FILE: hdl/hhr_front.sv
module hhr_front
    import hhr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [HUE_W-1:0]      hue_sixteenths,
    input  logic [PCT_IN_W-1:0]   first_percent,
    input  logic [PCT_IN_W-1:0]   second_percent,
    output logic                  item_valid,
    input  logic                  item_ready,
    output item_t                 item
);

    localparam int X_W = HUE_W + 2;
    localparam int K_W = 14;
    localparam logic [X_W-2:0] K_WRAP = 17'd5760;

    // Hue term of one channel: k = (offset + hue) truncating-mod 5760, then
    // m = clamp(min(k - 1440, 4320 - k), -480, 480).
    function automatic logic [M_W-1:0] chan_m(input logic [HUE_W-1:0] hue,
                                               input logic [X_W-1:0] offset);
        logic signed [X_W-1:0] x;
        logic [X_W-2:0]        ax;
        logic [X_W-2:0]        r;
        logic signed [K_W-1:0] k;
        logic signed [K_W:0]   a;
        logic signed [K_W:0]   b;
        logic signed [K_W:0]   mm;
        x = $signed({{2{hue[HUE_W-1]}}, hue}) + $signed(offset);
        ax = x[X_W-1] ? (X_W-1)'(-x) : x[X_W-2:0];
        r = ax;
        for (int j = 1; j <= 6; j++) begin
            if (ax >= (X_W-1)'(j) * K_WRAP) begin
                r = ax - (X_W-1)'(j) * K_WRAP;
            end
        end
        k = x[X_W-1] ? -$signed(K_W'(r)) : $signed(K_W'(r));
        a = (K_W+1)'(k) - (K_W+1)'(1440);
        b = (K_W+1)'(4320) - (K_W+1)'(k);
        mm = (a < b) ? a : b;
        if (mm > (K_W+1)'(480)) begin
            mm = (K_W+1)'(480);
        end
        if (mm < -(K_W+1)'(480)) begin
            mm = -(K_W+1)'(480);
        end
        return mm[M_W-1:0];
    endfunction

    logic             valid_reg;
    item_t            item_reg;
    item_t            item_next;
    logic [PCT_W-1:0] p1;
    logic [PCT_W-1:0] p2;
    logic [PCT_W:0]   sum;

    assign in_ready = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item = item_reg;

    always_comb
    begin
        p1 = (first_percent > PCT_IN_W'(PCT_FULL)) ? PCT_FULL : first_percent[PCT_W-1:0];
        p2 = (second_percent > PCT_IN_W'(PCT_FULL)) ? PCT_FULL : second_percent[PCT_W-1:0];
        sum = {1'b0, p1} + {1'b0, p2};
        item_next.p1 = p1;
        item_next.p2 = p2;
        item_next.mn = (p2 < PCT_FULL - p2) ? p2 : PCT_FULL - p2;
        item_next.rest = PCT_W'((PCT_W+1)'(PCT_FULL) - sum);
        if (!operation) begin
            item_next.cls = CLS_HSL;
        end else if (sum >= (PCT_W+1)'(PCT_FULL)) begin
            item_next.cls = CLS_GREY;
        end else begin
            item_next.cls = CLS_HWB;
        end
        item_next.m[0] = chan_m(hue_sixteenths, X_W'(0));
        item_next.m[1] = chan_m(hue_sixteenths, X_W'(3840));
        item_next.m[2] = chan_m(hue_sixteenths, X_W'(1920));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: hdl/hhr_queue.sv
module hhr_queue
    import hhr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_item = entry_reg[rd_ptr_reg];
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/hhr_back.sv
module hhr_back
    import hhr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  item_t            item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [Q_W-1:0]   red,
    output logic [Q_W-1:0]   green,
    output logic [Q_W-1:0]   blue
);

    // Stage 0 forms p1*mn, stage 1 the numerators, stage 2 the divider
    // operands, then one stage per quotient bit.
    localparam int STAGES = 3 + Q_W;

    logic                     adv;
    logic [STAGES-1:0]        v_reg;

    item_t                    a_item_reg;
    logic [2*PCT_W-1:0]       a_pm_reg;

    logic signed [NUM_W-1:0]  b_num_reg [NUM_CH];
    logic [DEN_W-1:0]         b_den_reg;
    logic signed [NUM_W-1:0]  b_num_next [NUM_CH];
    logic [DEN_W-1:0]         b_den_next;

    logic [DIVN_W-1:0]        c_n_reg [NUM_CH];
    logic [DIVD_W-1:0]        c_d_reg;
    logic [DIVN_W-1:0]        c_n_next [NUM_CH];

    logic [DIVN_W-1:0]        d_rem_reg [Q_W][NUM_CH];
    logic [Q_W-1:0]           d_q_reg [Q_W][NUM_CH];
    logic [DIVD_W-1:0]        d_d_reg [Q_W];

    // The whole pipeline moves together whenever the output is free.
    assign adv = !v_reg[STAGES-1] || out_ready;
    assign item_ready = adv;
    assign out_valid = v_reg[STAGES-1];
    assign red = d_q_reg[Q_W-1][0];
    assign green = d_q_reg[Q_W-1][1];
    assign blue = d_q_reg[Q_W-1][2];

    always_comb
    begin
        logic signed [NUM_W-1:0] mv;
        logic [NUM_W-1:0]        cn;
        for (int c = 0; c < NUM_CH; c++) begin
            mv = NUM_W'($signed(a_item_reg.m[c]));
            case (a_item_reg.cls)
                CLS_HSL:
                begin
                    b_num_next[c] = $signed(NUM_W'(a_item_reg.p2) * HSL_LSCALE)
                                  - $signed(NUM_W'(a_pm_reg)) * mv;
                end
                CLS_HWB:
                begin
                    b_num_next[c] = ($signed(K_UNIT) - mv) * $signed(NUM_W'(a_item_reg.rest))
                                  + $signed(NUM_W'(a_item_reg.p1) * HWB_WSCALE);
                end
                default:
                begin
                    b_num_next[c] = $signed(NUM_W'(a_item_reg.p1));
                end
            endcase
        end
        case (a_item_reg.cls)
            CLS_HSL:  b_den_next = HSL_DEN;
            CLS_HWB:  b_den_next = HWB_DEN;
            default:  b_den_next = DEN_W'(a_item_reg.p1) + DEN_W'(a_item_reg.p2);
        endcase
        // Clamp to [0, den] and form num*510 + den for the rounding divide.
        for (int c = 0; c < NUM_CH; c++) begin
            if (b_num_reg[c] < 0) begin
                cn = '0;
            end else if (b_num_reg[c] > $signed(NUM_W'(b_den_reg))) begin
                cn = NUM_W'(b_den_reg);
            end else begin
                cn = b_num_reg[c];
            end
            c_n_next[c] = (DIVN_W'(cn) << 9) - (DIVN_W'(cn) << 1) + DIVN_W'(b_den_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[STAGES-2:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        logic [DIVN_W-1:0] rem;
        logic [DIVN_W-1:0] trial;
        logic [Q_W-1:0]    q;
        if (adv) begin
            a_item_reg <= item;
            a_pm_reg <= (2*PCT_W)'(item.p1) * (2*PCT_W)'(item.mn);
            b_den_reg <= b_den_next;
            c_d_reg <= {b_den_reg, 1'b0};
            for (int c = 0; c < NUM_CH; c++) begin
                b_num_reg[c] <= b_num_next[c];
                c_n_reg[c] <= c_n_next[c];
            end
            // Restoring divide, most significant quotient bit first.
            for (int s = 0; s < Q_W; s++) begin
                d_d_reg[s] <= (s == 0) ? c_d_reg : d_d_reg[(s == 0) ? 0 : s - 1];
                for (int c = 0; c < NUM_CH; c++) begin
                    if (s == 0) begin
                        rem = c_n_reg[c];
                        q = '0;
                        trial = DIVN_W'(c_d_reg) << (Q_W - 1);
                    end else begin
                        rem = d_rem_reg[(s == 0) ? 0 : s - 1][c];
                        q = d_q_reg[(s == 0) ? 0 : s - 1][c];
                        trial = DIVN_W'(d_d_reg[(s == 0) ? 0 : s - 1]) << (Q_W - 1 - s);
                    end
                    if (rem >= trial) begin
                        d_rem_reg[s][c] <= rem - trial;
                        d_q_reg[s][c] <= {q[Q_W-2:0], 1'b1};
                    end else begin
                        d_rem_reg[s][c] <= rem;
                        d_q_reg[s][c] <= {q[Q_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

endmodule

FILE: hdl/hsl_hwb_to_rgb8.sv
// HSL / HWB to 8-bit RGB color converter.
//
// Input channel: in_valid / in_ready carry one color request made of
// operation (0 = HSL, 1 = HWB), a signed hue in sixteenths of a degree and
// two percentages in sixteenths of a percent, clamped to 100 percent.
// Output channel: out_valid / out_ready carry red, green and blue.
// Every request gives exactly one result, in request order.
//
// A front stage clamps the percentages, works out the three hue slopes and
// classifies the request as HSL, HWB or HWB grey. A short queue passes it to
// the back pipeline: a product stage, a numerator stage, a clamp stage and an
// eight-stage restoring divider that yields one rounded bit per stage.
//
// A request passes the front register, the queue and the back stages to
// out_valid. One request is accepted every cycle unless the receiver stalls;
// the rate is set by the divider pipeline, which takes a new operand set each
// cycle. When the receiver holds out_ready low the back pipeline freezes with
// its result on the ports, the queue fills and in_ready then drops.
// Reset clears all valid state; no result is presented until requests arrive.
module hsl_hwb_to_rgb8
    import hhr_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  logic [HUE_W-1:0]     hue_sixteenths,
    input  logic [PCT_IN_W-1:0]  first_percent,
    input  logic [PCT_IN_W-1:0]  second_percent,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [Q_W-1:0]       red,
    output logic [Q_W-1:0]       green,
    output logic [Q_W-1:0]       blue
);

    // Front to queue.
    logic  fq_valid;
    logic  fq_ready;
    item_t fq_item;

    // Queue to back.
    logic  qb_valid;
    logic  qb_ready;
    item_t qb_item;

    hhr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .hue_sixteenths (hue_sixteenths),
        .first_percent  (first_percent),
        .second_percent (second_percent),
        .item_valid     (fq_valid),
        .item_ready     (fq_ready),
        .item           (fq_item)
    );

    hhr_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    hhr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (qb_valid),
        .item_ready (qb_ready),
        .item       (qb_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

endmodule

FILE: hdl/hhr_checker.sv
module hhr_checker
    import hhr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_ready,
    input  logic            out_valid,
    input  logic            out_ready,
    input  logic [Q_W-1:0]  red,
    input  logic [Q_W-1:0]  green,
    input  logic [Q_W-1:0]  blue
);

    // A stalled result stays on the ports unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled result changed or dropped");

    // Reset empties the pipeline.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("result presented during reset");

    // A free receiver in the last cycle leaves room in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_ready) |-> in_ready)
    else $error("request stalled although the receiver was free");

endmodule

bind hsl_hwb_to_rgb8 hhr_checker u_checker (.*);

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hhr_pkg::*;

    // Operation codes of a colour request.
    localparam logic OP_HSL = 1'b0;
    localparam logic OP_HWB = 1'b1;

    // Percent full scale, hue slope unit and hue wrap, all as plain integers.
    localparam int FULL_PCT = 1600;
    localparam int SLOPE_UNIT = 480;
    localparam int HUE_WRAP = 5760;

    typedef struct {
        logic                op;
        logic [HUE_W-1:0]    hue;
        logic [PCT_IN_W-1:0] pa;
        logic [PCT_IN_W-1:0] pb;
    } color_req_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                operation;
    logic [HUE_W-1:0]    hue_sixteenths;
    logic [PCT_IN_W-1:0] first_percent;
    logic [PCT_IN_W-1:0] second_percent;
    logic                out_valid;
    logic                out_ready;
    logic [Q_W-1:0]      red;
    logic [Q_W-1:0]      green;
    logic [Q_W-1:0]      blue;

    color_req_t pending_reqs[$];
    rgb_t       expected_rgb[$];
    int         error_count;

    hsl_hwb_to_rgb8 i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .hue_sixteenths (hue_sixteenths),
        .first_percent  (first_percent),
        .second_percent (second_percent),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red            (red),
        .green          (green),
        .blue           (blue)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Percentages above full scale saturate at 100 percent.
    function automatic longint sat_pct(logic [PCT_IN_W-1:0] raw);
        return (raw > FULL_PCT) ? FULL_PCT : longint'(raw);
    endfunction

    // Hue slope of one channel in units of 1/480. The modulo truncates toward
    // zero, so a negative sum of phase and hue stays negative, and the slope then
    // saturates at the rails instead of wrapping around the color wheel.
    function automatic longint hue_slope(int chan, logic [HUE_W-1:0] hue);
        int phase;
        int lo;
        int hi;
        int s;
        phase = (chan == 0) ? 0 : ((chan == 1) ? 3840 : 1920);
        phase = (phase + int'($signed(hue))) % HUE_WRAP;
        lo = phase - 3 * SLOPE_UNIT;
        hi = 9 * SLOPE_UNIT - phase;
        s = (lo < hi) ? lo : hi;
        if (s > SLOPE_UNIT)
            s = SLOPE_UNIT;
        if (s < -SLOPE_UNIT)
            s = -SLOPE_UNIT;
        return s;
    endfunction

    // Clamp num/den to [0,1] and round half up to eight bits, exactly.
    function automatic logic [7:0] to_byte(longint num, longint den);
        if (num < 0)
            num = 0;
        if (num > den)
            num = den;
        return 8'((num * 510 + den) / (2 * den));
    endfunction

    function automatic rgb_t color_to_rgb(color_req_t req);
        longint     w;
        longint     k;
        longint     near_edge;
        longint     num;
        logic [7:0] ch[3];
        rgb_t       res;
        w = sat_pct(req.pa);
        k = sat_pct(req.pb);
        for (int c = 0; c < 3; c++)
        begin
            if (req.op == OP_HSL)
            begin
                near_edge = (k < FULL_PCT - k) ? k : FULL_PCT - k;
                num = k * FULL_PCT * SLOPE_UNIT - w * near_edge * hue_slope(c, req.hue);
                ch[c] = to_byte(num, longint'(FULL_PCT) * FULL_PCT * SLOPE_UNIT);
            end
            else if (w + k >= FULL_PCT)
            begin
                // Whiteness and blackness at or past full give a pure grey.
                ch[c] = to_byte(w, w + k);
            end
            else
            begin
                num = (SLOPE_UNIT - hue_slope(c, req.hue)) * (FULL_PCT - w - k)
                    + 2 * SLOPE_UNIT * w;
                ch[c] = to_byte(num, 2 * SLOPE_UNIT * FULL_PCT);
            end
        end
        res.r = ch[0];
        res.g = ch[1];
        res.b = ch[2];
        return res;
    endfunction

    function automatic color_req_t make_req(logic op, logic [HUE_W-1:0] hue,
                                            logic [PCT_IN_W-1:0] pa,
                                            logic [PCT_IN_W-1:0] pb);
        color_req_t req;
        req.op = op;
        req.hue = hue;
        req.pa = pa;
        req.pb = pb;
        return req;
    endfunction

    // Mostly in-range percentages, with some over full scale and the corners.
    function automatic logic [PCT_IN_W-1:0] rand_pct();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return PCT_IN_W'($urandom_range(0, FULL_PCT));
        else if (sel < 8)
            return PCT_IN_W'($urandom);
        else if (sel == 8)
            return PCT_IN_W'(FULL_PCT);
        return '0;
    endfunction

    // Mostly hues within one turn either way, the rest anywhere in 16 bits.
    function automatic logic [HUE_W-1:0] rand_hue();
        if ($urandom_range(0, 3) != 0)
            return HUE_W'($urandom_range(0, 2 * HUE_WRAP) - HUE_WRAP);
        return HUE_W'($urandom);
    endfunction

    // Driver: bursts of requests separated by random gaps. Inputs change on
    // the falling edge; acceptance is judged from what the rising edge saw.
    int  burst_left;
    int  gap_left;
    bit  accepted_last;

    always @(posedge clk)
        accepted_last <= in_valid && in_ready;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= 1'b0;
            hue_sixteenths <= '0;
            first_percent <= '0;
            second_percent <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!in_valid || accepted_last)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                color_req_t req;
                req = pending_reqs.pop_front();
                expected_rgb.push_back(color_to_rgb(req));
                in_valid <= 1'b1;
                operation <= req.op;
                hue_sixteenths <= req.hue;
                first_percent <= req.pa;
                second_percent <= req.pb;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stalls follow a slowly changing duty pattern, including
    // stretches with out_ready held high.
    int stall_phase;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 256) % 4)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((stall_phase % 7) < 4);
            endcase
        end
    end

    // Monitor: every accepted result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rgb.size() == 0)
            begin
                error_count <= error_count + 1;
                if (error_count < 10)
                    $display("Unexpected result r=%0d g=%0d b=%0d", red, green, blue);
            end
            else
            begin
                rgb_t want;
                want = expected_rgb.pop_front();
                if (want.r !== red || want.g !== green || want.b !== blue)
                begin
                    error_count <= error_count + 1;
                    if (error_count < 10)
                        $display("Mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want.r, want.g, want.b, red, green, blue);
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests: field extremes, both operations, clamped
        // percentages, negative hues and HWB at or past full.
        pending_reqs.push_back(make_req(OP_HSL, 16'h0000, 12'd1600, 12'd800));
        pending_reqs.push_back(make_req(OP_HSL, 16'h7FFF, 12'hFFF, 12'hFFF));
        pending_reqs.push_back(make_req(OP_HSL, 16'h8000, 12'd1600, 12'd800));
        pending_reqs.push_back(make_req(OP_HSL, 16'hFFFF, 12'd0, 12'd0));
        pending_reqs.push_back(make_req(OP_HSL, 16'd1920, 12'd1601, 12'd800));
        pending_reqs.push_back(make_req(OP_HSL, 16'd3840, 12'd1600, 12'd400));
        pending_reqs.push_back(make_req(OP_HSL, -16'sd1920, 12'd1600, 12'd800));
        pending_reqs.push_back(make_req(OP_HSL, 16'd5760, 12'd1200, 12'd1200));
        pending_reqs.push_back(make_req(OP_HSL, 16'hAAAA, 12'hAAA, 12'h555));
        pending_reqs.push_back(make_req(OP_HSL, 16'h5555, 12'h555, 12'hAAA));
        pending_reqs.push_back(make_req(OP_HWB, 16'd0, 12'd0, 12'd0));
        pending_reqs.push_back(make_req(OP_HWB, 16'd1920, 12'd400, 12'd400));
        pending_reqs.push_back(make_req(OP_HWB, -16'sd960, 12'd200, 12'd100));
        pending_reqs.push_back(make_req(OP_HWB, 16'd100, 12'd800, 12'd800));
        pending_reqs.push_back(make_req(OP_HWB, 16'd100, 12'd1600, 12'd0));
        pending_reqs.push_back(make_req(OP_HWB, 16'd100, 12'd0, 12'd1600));
        pending_reqs.push_back(make_req(OP_HWB, 16'd100, 12'hFFF, 12'hFFF));
        pending_reqs.push_back(make_req(OP_HWB, 16'h8000, 12'd1000, 12'd900));
        pending_reqs.push_back(make_req(OP_HWB, 16'h7FFF, 12'd799, 12'd800));
        pending_reqs.push_back(make_req(OP_HWB, 16'hFFFF, 12'd0, 12'd1599));

        for (int i = 0; i < 1000; i++)
            pending_reqs.push_back(make_req(1'($urandom), rand_hue(), rand_pct(), rand_pct()));

        wait (pending_reqs.size() == 0);
        @(posedge clk);
        wait (!in_valid && expected_rgb.size() == 0);
        // Allow the pipeline to drain so stray results still get caught.
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
hdl/hhr_pkg.sv
hdl/hhr_front.sv
hdl/hhr_queue.sv
hdl/hhr_back.sv
hdl/hsl_hwb_to_rgb8.sv
hdl/hhr_checker.sv
sim/testbench.sv
